// ===== rtl/infix_expression_evaluator_assert.svh =====
// Assertion macros for the expression evaluator checker.
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define IEE_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define IEE_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/iee_pkg.sv =====
// Shared types and constants of the expression evaluator.
package iee_pkg;
  localparam int OperandDepthDef  = 16;
  localparam int OperatorDepthDef = 16;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3, OP_OTHER = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_MALFORMED = 2'd2, ST_OVERFLOW = 2'd3
  } status_t;

  // Kind of a classified word handed to the back end.
  typedef enum logic [1:0] {
    K_NOP = 2'd0, K_DIGIT = 2'd1, K_LETTER = 2'd2, K_OPER = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    op_t        op;
    logic       space;
    logic       last;
  } tok_t;

  function automatic logic [1:0] rank_of(op_t c);
    logic [1:0] r;
    r = 2'd0;
    if (c == OP_ADD || c == OP_SUB) r = 2'd1;
    else if (c == OP_MUL || c == OP_DIV) r = 2'd2;
    return r;
  endfunction
endpackage

// ===== rtl/iee_front.sv =====
// Front end: accepts characters and classifies them into tokens.
module iee_front (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     ch,
  input  logic           last,
  input  logic           valid,
  output logic           ready,
  output iee_pkg::tok_t  tok,
  output logic           tok_valid,
  input  logic           tok_ready
);
  // Two-entry queue.
  iee_pkg::tok_t q [2];
  logic [1:0]    cnt;
  logic          rp, wp;
  iee_pkg::tok_t t;

  always_comb begin
    t = '0;
    t.last = last;
    t.kind = iee_pkg::K_NOP;
    t.op   = iee_pkg::OP_OTHER;
    if ((ch >= 8'd9 && ch <= 8'd13) || ch == 8'd32) begin
      t.space = 1'b1;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      t.kind  = iee_pkg::K_DIGIT;
      t.digit = 4'(ch - 8'h30);
    end else if ((ch >= 8'h41 && ch <= 8'h5a) || (ch >= 8'h61 && ch <= 8'h7a)) begin
      t.kind = iee_pkg::K_LETTER;
    end else begin
      t.kind = iee_pkg::K_OPER;
      priority if (ch == 8'h2b) t.op = iee_pkg::OP_ADD;
      else if (ch == 8'h2d) t.op = iee_pkg::OP_SUB;
      else if (ch == 8'h2a) t.op = iee_pkg::OP_MUL;
      else if (ch == 8'h2f) t.op = iee_pkg::OP_DIV;
      else t.op = iee_pkg::OP_OTHER;
    end
  end

  assign ready     = cnt != 2'd2;
  assign tok_valid = cnt != 2'd0;
  assign tok       = q[rp];

  always_ff @(posedge clk) begin
    if (valid && ready) q[wp] <= t;
    if (rst) begin
      cnt <= '0; rp <= 1'b0; wp <= 1'b0;
    end else begin
      if (valid && ready) wp <= ~wp;
      if (tok_valid && tok_ready) rp <= ~rp;
      cnt <= cnt + 2'(valid && ready) - 2'(tok_valid && tok_ready);
    end
  end
endmodule

// ===== rtl/iee_div.sv =====
// Iterative 32-bit unsigned divider, one quotient bit per cycle.
module iee_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] q
);
  logic [31:0] rem, quo, dvs;
  logic [5:0]  n;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};
  assign q     = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; n <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; n <= 6'd32; rem <= '0; quo <= a; dvs <= b;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0]; quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]}; quo <= {quo[30:0], 1'b0};
        end
        n <= n - 6'd1;
        if (n == 6'd1) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/iee_back.sv =====
// Back end: stack machine that carries out the tokens.
module iee_back #(
  parameter int OPERAND_DEPTH  = iee_pkg::OperandDepthDef,
  parameter int OPERATOR_DEPTH = iee_pkg::OperatorDepthDef
) (
  input  logic                clk,
  input  logic                rst,
  input  iee_pkg::tok_t       tok,
  input  logic                tok_valid,
  output logic                tok_ready,
  output logic signed [31:0]  value,
  output logic [1:0]          status,
  output logic                valid,
  input  logic                ready
);
  localparam int AW = $clog2(OPERAND_DEPTH + 1);
  localparam int OW = $clog2(OPERATOR_DEPTH + 1);
  localparam int AI = (OPERAND_DEPTH > 1) ? $clog2(OPERAND_DEPTH) : 1;
  localparam int OI = (OPERATOR_DEPTH > 1) ? $clog2(OPERATOR_DEPTH) : 1;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_TOKEN  = 10'b0000000010,
    S_PUSH   = 10'b0000000100,
    S_RCHK   = 10'b0000001000,
    S_RRD    = 10'b0000010000,
    S_RMUL   = 10'b0000100000,
    S_RDIV   = 10'b0001000000,
    S_OPUSH  = 10'b0010000000,
    S_FINAL  = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t state;
  logic [31:0] astk [OPERAND_DEPTH];
  iee_pkg::op_t ostk [OPERATOR_DEPTH];
  logic [AW-1:0] acnt;
  logic [OW-1:0] ocnt;
  logic [31:0] pend, pv, ra, rb, prod;
  logic [1:0]  mode, err;
  iee_pkg::tok_t cur;
  iee_pkg::op_t  rop;
  logic [31:0] pend_next;
  logic        dstart, ddone, neg;
  logic [31:0] dq, ua, ub;

  assign pend_next = 32'(pend * 32'd10) + {28'd0, cur.digit};
  assign ua = ra[31] ? -ra : ra;
  assign ub = rb[31] ? -rb : rb;

  iee_div u_div (.clk, .rst, .start(dstart), .a(ua), .b(ub), .done(ddone), .q(dq));

  assign tok_ready = state == S_IDLE;
  assign valid     = state == S_OUT;

  always_ff @(posedge clk) begin
    dstart <= 1'b0;
    if (rst) begin
      state <= S_IDLE; acnt <= '0; ocnt <= '0; pend <= '0; mode <= '0; err <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (tok_valid) begin
          cur <= tok; state <= S_TOKEN;
        end
        S_TOKEN: begin
          state <= cur.last ? S_FINAL : S_IDLE;
          if (err == 2'd0) begin
            if (cur.space || cur.kind == iee_pkg::K_OPER) begin
              if (mode != 2'd0) begin
                pv <= pend; state <= S_PUSH;
              end else if (cur.kind == iee_pkg::K_OPER) state <= S_RCHK;
              mode <= 2'd0; pend <= '0;
            end else if (cur.kind == iee_pkg::K_DIGIT) begin
              if (mode == 2'd2) begin
                pv <= pend; state <= S_PUSH;
              end else begin
                pend <= pend_next; mode <= 2'd1;
              end
            end else if (cur.kind == iee_pkg::K_LETTER) begin
              if (mode != 2'd0) mode <= 2'd2;
              else begin
                pv <= 32'd1; state <= S_PUSH;
              end
            end
          end
        end
        S_PUSH: begin
          if (err == 2'd0) begin
            if (acnt >= AW'(OPERAND_DEPTH)) err <= iee_pkg::ST_OVERFLOW;
            else begin
              astk[acnt[AI-1:0]] <= pv; acnt <= acnt + AW'(1);
            end
          end
          // Digit after letters: the push was the old literal; start a new one.
          if (cur.kind == iee_pkg::K_DIGIT && !cur.space) begin
            pend <= {28'd0, cur.digit}; mode <= 2'd1;
            state <= cur.last ? S_FINAL : S_IDLE;
          end else if (cur.kind == iee_pkg::K_OPER) state <= S_RCHK;
          else state <= cur.last ? S_FINAL : S_IDLE;
        end
        S_RCHK: begin
          if (err != 2'd0) state <= cur.last ? S_FINAL : S_IDLE;
          else if (ocnt != '0 &&
                   iee_pkg::rank_of(ostk[OI'(ocnt - OW'(1))]) >= iee_pkg::rank_of(cur.op))
            state <= S_RRD;
          else state <= S_OPUSH;
        end
        S_RRD: begin
          if (acnt < AW'(2) || ocnt == '0) begin
            err <= iee_pkg::ST_MALFORMED;
            state <= cur.kind == iee_pkg::K_OPER ? S_RCHK : S_FINAL;
          end else begin
            rb  <= astk[AI'(acnt - AW'(1))];
            ra  <= astk[AI'(acnt - AW'(2))];
            rop <= ostk[OI'(ocnt - OW'(1))];
            acnt <= acnt - AW'(2); ocnt <= ocnt - OW'(1);
            state <= S_RMUL;
          end
        end
        S_RMUL: begin
          unique case (rop)
            iee_pkg::OP_ADD: begin pv <= ra + rb; state <= S_PUSH; end
            iee_pkg::OP_SUB: begin pv <= ra - rb; state <= S_PUSH; end
            iee_pkg::OP_MUL: begin prod <= ra * rb; state <= S_RDIV; end
            iee_pkg::OP_DIV: begin
              if (rb == '0) begin
                err <= iee_pkg::ST_DIV0;
                state <= cur.kind == iee_pkg::K_OPER ? S_RCHK : S_FINAL;
              end else begin
                dstart <= 1'b1; neg <= ra[31] ^ rb[31]; state <= S_RDIV;
              end
            end
            default: begin pv <= '0; state <= S_PUSH; end
          endcase
        end
        S_RDIV: begin
          if (rop == iee_pkg::OP_MUL) begin
            pv <= prod; state <= S_PUSH;
          end else if (ddone) begin
            pv <= neg ? -dq : dq; state <= S_PUSH;
          end
        end
        S_OPUSH: begin
          if (ocnt >= OW'(OPERATOR_DEPTH)) err <= iee_pkg::ST_OVERFLOW;
          else begin
            ostk[ocnt[OI-1:0]] <= cur.op; ocnt <= ocnt + OW'(1);
          end
          state <= cur.last ? S_FINAL : S_IDLE;
        end
        S_FINAL: begin
          // Reductions re-enter here via S_PUSH with a non-operator token.
          cur.kind <= iee_pkg::K_NOP; cur.space <= 1'b0; cur.last <= 1'b1;
          if (err == 2'd0 && mode != 2'd0) begin
            pv <= pend; mode <= 2'd0; pend <= '0; state <= S_PUSH;
          end else if (err == 2'd0 && ocnt != '0) state <= S_RRD;
          else begin
            if (err == 2'd0 && acnt == '0) begin
              status <= iee_pkg::ST_MALFORMED; value <= '0;
            end else if (err != 2'd0) begin
              status <= err; value <= '0;
            end else begin
              status <= iee_pkg::ST_OK; value <= astk[AI'(acnt - AW'(1))];
            end
            state <= S_OUT;
          end
        end
        S_OUT: if (ready) begin
          state <= S_IDLE; acnt <= '0; ocnt <= '0; pend <= '0; mode <= '0; err <= '0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/infix_expression_evaluator.sv =====
// Top level of the infix expression evaluator.
// Usage:
//   Input channel: ch (ASCII byte) and last, handshake valid_in/ready_in.
//   Output channel: value and status, handshake valid/ready, one word per
//   expression, produced after the word marked last.
//   A two-entry queue parts the character classifier from the stack machine.
//   Each character passes S_IDLE and S_TOKEN; a literal push adds S_PUSH.
//   An operator reduction runs S_RRD, S_RMUL and S_PUSH; a multiply adds
//   S_RDIV, and a division waits there for the bit-serial divider. The final
//   flush adds one reduction per stacked operator, then forms the result in S_FINAL.
//   Reset clears all counters and state; the stacks need no clearing.
//   While the receiver stalls, the result is held and the machine waits;
//   the front queue keeps taking characters until it holds two.
module infix_expression_evaluator #(
  parameter int OPERAND_DEPTH  = iee_pkg::OperandDepthDef,
  parameter int OPERATOR_DEPTH = iee_pkg::OperatorDepthDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         ch,
  input  logic               last,
  input  logic               valid_in,
  output logic               ready_in,
  output logic signed [31:0] value,
  output logic [1:0]         status,
  output logic               valid,
  input  logic               ready
);
  iee_pkg::tok_t tok;
  logic tok_valid, tok_ready;

  iee_front u_front (.clk, .rst, .ch, .last, .valid(valid_in), .ready(ready_in),
                     .tok, .tok_valid, .tok_ready);

  iee_back #(.OPERAND_DEPTH(OPERAND_DEPTH), .OPERATOR_DEPTH(OPERATOR_DEPTH)) u_back (
    .clk, .rst, .tok, .tok_valid, .tok_ready, .value, .status, .valid, .ready);
endmodule

// ===== rtl/iee_checker.sv =====
// Port-level checker for the expression evaluator, bound to the top level.
`include "infix_expression_evaluator_assert.svh"
module iee_checker (
  input logic        clk,
  input logic        rst,
  input logic [31:0] value,
  input logic [1:0]  status,
  input logic        valid,
  input logic        ready
);
  `IEE_ASSERT_IMP(a_err_zero, valid && status != iee_pkg::ST_OK, value == 32'd0)
  `IEE_ASSERT_NXT(a_hold, valid && !ready, valid && $stable(value) && $stable(status))
  `IEE_ASSERT_NXT(a_one_out, valid && ready, !valid)
endmodule

bind infix_expression_evaluator iee_checker u_chk (.clk, .rst,
  .value, .status, .valid, .ready);

// ===== verif/infix_expression_evaluator_tb.sv =====
// Testbench for the infix expression evaluator: random and directed expressions, scoreboard.
`timescale 1ns / 100ps

module infix_expression_evaluator_tb;
  import iee_pkg::*;

  localparam int OPND_DEPTH = 16;
  localparam int OPER_DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int CALM_ITEMS = 200;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } eval_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [7:0] ch = '0;
  logic last = 1'b0;
  logic valid_in = 1'b0;
  logic ready_in;
  logic signed [31:0] value;
  logic [1:0] status;
  logic valid;
  logic ready = 1'b0;

  char_word_t char_queue[$];
  eval_word_t expected_evals[$];
  int errors = 0;
  int sent_count = 0;
  int total_items = 0;
  bit hold_active = 0;
  logic calm;

  // predictor state
  logic [31:0] p_opnd[OPND_DEPTH];
  int          p_nopnd;
  op_t         p_oper[OPER_DEPTH];
  int          p_noper;
  logic [31:0] p_pend;
  int          p_mode;
  status_t     p_err;

  infix_expression_evaluator i_dut (
    .clk(clk), .rst(rst), .ch(ch), .last(last), .valid_in(valid_in),
    .ready_in(ready_in), .value(value), .status(status), .valid(valid),
    .ready(ready)
  );

  always #5 clk = ~clk;

  assign calm = sent_count > total_items - CALM_ITEMS;

  function automatic int op_rank(op_t c);
    if (c == OP_ADD || c == OP_SUB) return 1;
    if (c == OP_MUL || c == OP_DIV) return 2;
    return 0;
  endfunction

  function automatic void eval_clear();
    p_nopnd = 0; p_noper = 0; p_pend = '0; p_mode = 0; p_err = ST_OK;
  endfunction

  function automatic void eval_push(logic [31:0] v);
    if (p_err != ST_OK) return;
    if (p_nopnd >= OPND_DEPTH) begin
      p_err = ST_OVERFLOW;
      return;
    end
    p_opnd[p_nopnd] = v;
    p_nopnd++;
  endfunction

  function automatic void eval_reduce();
    logic [31:0] a, b, r, ua, ub, q;
    op_t code;
    if (p_nopnd < 2 || p_noper == 0) begin
      p_err = ST_MALFORMED;
      return;
    end
    b = p_opnd[p_nopnd-1];
    a = p_opnd[p_nopnd-2];
    p_nopnd -= 2;
    code = p_oper[p_noper-1];
    p_noper--;
    case (code)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      OP_DIV: begin
        if (b == 0) begin
          p_err = ST_DIV0;
          return;
        end
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        r = (a[31] != b[31]) ? -q : q;
      end
      default: r = '0;
    endcase
    eval_push(r);
  endfunction

  function automatic void eval_end_token();
    if (p_mode != 0) eval_push(p_pend);
    p_mode = 0;
    p_pend = '0;
  endfunction

  // returns 1 and the expected word when the char closes an expression
  function automatic bit eval_char(char_word_t w, output eval_word_t res);
    op_t code;
    logic [7:0] c;
    c = w.ch;
    res = '0;
    if (p_err == ST_OK) begin
      if ((c >= 9 && c <= 13) || c == 32) eval_end_token();
      else if (c >= "0" && c <= "9") begin
        if (p_mode == 2) eval_end_token();
        p_mode = 1;
        p_pend = p_pend * 10 + 32'(c - "0");
      end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
        if (p_mode != 0) p_mode = 2;
        else eval_push(32'd1);
      end else begin
        code = (c == "+") ? OP_ADD : (c == "-") ? OP_SUB :
               (c == "*") ? OP_MUL : (c == "/") ? OP_DIV : OP_OTHER;
        eval_end_token();
        while (p_err == ST_OK && p_noper > 0 &&
               op_rank(p_oper[p_noper-1]) >= op_rank(code))
          eval_reduce();
        if (p_err == ST_OK) begin
          if (p_noper >= OPER_DEPTH) p_err = ST_OVERFLOW;
          else begin
            p_oper[p_noper] = code;
            p_noper++;
          end
        end
      end
    end
    if (!w.last) return 0;
    if (p_err == ST_OK) eval_end_token();
    while (p_err == ST_OK && p_noper > 0) eval_reduce();
    if (p_err == ST_OK && p_nopnd == 0) p_err = ST_MALFORMED;
    res.status = p_err;
    res.value = (p_err == ST_OK) ? p_opnd[p_nopnd-1] : '0;
    eval_clear();
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp_v, $time);
    errors++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++)
      char_queue.push_back('{ch: s[i], last: (i == s.len() - 1)});
  endtask

  function automatic logic [7:0] rand_char();
    int k;
    k = $urandom_range(0, 99);
    if (k < 35) return 8'("0" + $urandom_range(0, 9));
    if (k < 65) begin
      case ($urandom_range(0, 3))
        0: return "+";
        1: return "-";
        2: return "*";
        default: return "/";
      endcase
    end
    if (k < 75) return 8'("a" + $urandom_range(0, 25));
    if (k < 85) return " ";
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed: operand (op operand)*, random spacing
  task automatic add_random_expr();
    int n;
    string s;
    s = "";
    if ($urandom_range(0, 9) < 8) begin
      n = $urandom_range(0, 6);
      for (int i = 0; i <= n; i++) begin
        if (i > 0) begin
          case ($urandom_range(0, 4))
            0: s = {s, "+"};
            1: s = {s, "-"};
            2: s = {s, "*"};
            3: s = {s, "/"};
            default: if ($urandom_range(0, 9) == 0) s = {s, "%"}; else s = {s, "+"};
          endcase
        end
        if ($urandom_range(0, 3) == 0) s = {s, " "};
        if ($urandom_range(0, 5) == 0) s = {s, "x"};
        else begin
          for (int d = $urandom_range(1, 10); d > 0; d--)
            s = {s, string'(8'("0" + $urandom_range(0, 9)))};
          if ($urandom_range(0, 6) == 0) s = {s, "q"};
        end
      end
    end else begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) s = {s, string'(rand_char())};
    end
    if (s.len() == 0) s = "1";
    add_text(s);
  endtask

  // driver: sender idles in random bursts
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (valid_in && ready_in) sent_count <= sent_count + 1;
      if (!valid_in || ready_in) begin
        if (send_gap > 0 && !calm) begin
          send_gap <= send_gap - 1;
          valid_in <= 1'b0;
        end else if (char_queue.size() > 0 && (calm || $urandom_range(0, 9) != 0)) begin
          send_gap <= 0;
          ch <= char_queue[0].ch;
          last <= char_queue[0].last;
          valid_in <= 1'b1;
          void'(char_queue.pop_front());
        end else begin
          if (char_queue.size() > 0) send_gap <= $urandom_range(0, 11);
          valid_in <= 1'b0;
        end
      end
    end
  end

  // receiver stalls in bursts; one long hold-off driven by hold_active
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_active) ready <= 1'b0;
      else if (calm) ready <= 1'b1;
      else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        ready <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        stall_left <= $urandom_range(0, 11);
        ready <= 1'b0;
      end else ready <= 1'b1;
    end
  end

  // monitor
  eval_word_t exp_w;
  always @(posedge clk) begin
    if (!rst) begin
      if (valid_in && ready_in) begin
        if (eval_char('{ch: ch, last: last}, exp_w)) expected_evals.push_back(exp_w);
      end
      if (valid && ready) begin
        if (expected_evals.size() == 0) begin
          report_mismatch("unexpected word", value, 32'(status));
        end else begin
          if (value !== expected_evals[0].value)
            report_mismatch("value", value, expected_evals[0].value);
          if (status !== expected_evals[0].status)
            report_mismatch("status", 32'(status), 32'(expected_evals[0].status));
          void'(expected_evals.pop_front());
        end
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((valid_in && ready_in) || (valid && ready) || hold_active) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("infix_expression_evaluator test failed");
      $finish;
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin : hold_off
    wait (!rst);
    repeat (300) @(posedge clk);
    hold_active <= 1'b1;
    repeat (400) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin
    eval_clear();
    add_text("1+2*3");
    add_text("2147483647+1");
    add_text("4294967295");
    add_text("7/0");
    add_text("0-2147483648/0-1");
    add_text("-7/2");
    add_text("12ab3 4");
    add_text("x*y+z");
    add_text("5%3");
    add_text("\t9\n");
    add_text("+");
    add_text(" ");
    add_text("1 2 3");
    add_text("1+2+3+4+5+6+7+8+9+1+2+3+4+5+6+7+8");
    add_text("1*2*3*4*5*6*7*8*9*1*2*3*4*5*6*7*8");
    add_text("1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1");
    add_text("1 2 3 4 5 6 7 8 9 1 2 3 4 5 6 7 8");
    add_text("a+b+c+d+e+f+g+h+i+j+k+l+m+n+o+p+q");
    add_text("1+2*3-4/5+6*7");
    add_text({8'hff, 8'h80, "+", 8'h00});
    while (char_queue.size() < 1550) add_random_expr();
    char_queue.push_back('{ch: "1", last: 1'b1});
    total_items = char_queue.size();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (sent_count < total_items) @(posedge clk);
    while (expected_evals.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_evals.size() == 0)
      $display("infix_expression_evaluator test passed");
    else
      $display("infix_expression_evaluator test failed");
    $finish;
  end

endmodule
